### rtl/assert_macros.svh
// Assertion macros shared by the checking code of the block.
// Depends on nothing; take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge, quiet while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, quiet while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/bmst_pkg.sv
// Package of the bracket matching tree: sizes, node pair type, combine function.
// Depends on nothing.
package bmst_pkg;
	localparam int LEAVES     = 1024;
	localparam int COUNT_BITS = 16;
	localparam int LVLS       = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
	localparam int IDX_BITS   = 10;
	localparam int POS_BITS   = 15;
	localparam int NEG_BITS   = 16;
	localparam int CB         = COUNT_BITS;

	typedef logic signed [CB-1:0] cnt_t;

	typedef struct packed {
		cnt_t pos;
		cnt_t neg;
	} pair_t;

	localparam cnt_t CNT_MAX = cnt_t'((64'd1 << (CB - 1)) - 64'd1);
	localparam cnt_t CNT_MIN = cnt_t'(-(64'sd1 <<< (CB - 1)));

	// left child a, right child b
	function automatic pair_t join_pair(pair_t a, pair_t b);
		logic signed [CB+1:0] v;
		logic signed [CB+1:0] s;
		pair_t o;
		v = (CB+2)'(a.pos) + (CB+2)'(b.neg);
		o.pos = b.pos;
		o.neg = a.neg;
		if (v > 0) begin
			s = (CB+2)'(b.pos) + v;
			o.pos = (s > (CB+2)'(CNT_MAX)) ? CNT_MAX : s[CB-1:0];
		end else begin
			s = (CB+2)'(a.neg) + v;
			o.neg = (s < (CB+2)'(CNT_MIN)) ? CNT_MIN : s[CB-1:0];
		end
		return o;
	endfunction

	// clr marks a clearing walk: every level writes zero on its path
	typedef struct packed {
		logic go;
		logic wr;
		logic clr;
	} cell_ctl_t;
endpackage

### rtl/bmst_if.sv
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
interface bmst_if #(parameter int W = 1) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/bmst_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// Depends on nothing.
module bmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/bmst_cell.sv
// One tree level: holds the sibling pairs of its level and combines the
// passing pair with the stored sibling. Depends on bmst_pkg, bmst_ram.
module bmst_cell #(
	parameter int LVL = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bmst_pkg::cell_ctl_t       ctl_in,
	input  logic [bmst_pkg::LVLS-1:0] idx_in,
	input  bmst_pkg::pair_t           pair_in,
	output bmst_pkg::cell_ctl_t       ctl_out,
	output logic [bmst_pkg::LVLS-1:0] idx_out,
	output bmst_pkg::pair_t           pair_out
);
	import bmst_pkg::*;
	// level LVL holds 2^(LVLS-LVL) nodes; index of the node is idx >> LVL
	localparam int NB    = LVLS - LVL;
	localparam int DEPTH = 1 << NB;

	logic [NB-1:0]  node;
	logic [NB-1:0]  sib;
	pair_t          rd;
	cell_ctl_t      ctl_s1;
	logic [LVLS-1:0] idx_s1;
	pair_t          pair_s1;
	logic [NB-1:0]  node_s1;

	assign node = idx_in[LVLS-1:LVL];
	assign sib  = node ^ NB'(1);

	// the clearing walk after reset zeroes every entry before first use
	bmst_ram #(.WIDTH($bits(pair_t)), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ctl_in.go && ctl_in.wr), .waddr(node), .wdata(pair_in),
		.raddr(sib), .rdata(rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s1 <= '0;
		else
			ctl_s1 <= ctl_in;
	end
	always_ff @(posedge clk) begin
		idx_s1  <= idx_in;
		pair_s1 <= pair_in;
		node_s1 <= node;
	end

	assign ctl_out  = ctl_s1;
	assign idx_out  = idx_s1;
	assign pair_out = ctl_s1.clr ? '0 :
		(node_s1[0] ? join_pair(rd, pair_s1) : join_pair(pair_s1, rd));
endmodule

### rtl/bracket_match_segment_tree.sv
// Top level of the bracket matching segment tree.
// Depends on bmst_pkg, bmst_if, bmst_cell, assert_macros.svh.
//
// Usage:
//  in  : sink channel, word = {leaf_index, leaf_pos, leaf_neg}.
//  out : source channel, word = {root_pos, root_neg}.
//  Every accepted word overwrites one leaf and returns the root pair.
//  The tree is a chain of LVLS cells, one per level below the root; each
//  cell keeps its level in a small RAM, combines the passing pair with
//  the stored sibling and hands the parent pair on in the next cycle.
//  Result: the word walks through the chain of level cells, and the
//  root pair that it produces is caught in the output register.
//  Only one update is in flight at a time.
//  The root is held in a register and is what the result reports.
//  An index at or beyond LEAVES writes nothing and still walks the chain
//  without writing, so the root is reported unchanged.
//  Reset: asynchronous, clears control and the root, then a clearing pass
//  walks zero down every leaf path, one walk per leaf; input ready
//  stays low until the last zero walk has entered the chain.
//  Stall: the result waits in its output register until taken; the
//  next word is accepted once the result has left.
module bracket_match_segment_tree (
	input logic   clk,
	input logic   arst_n,
	bmst_if.sink   in,
	bmst_if.source out
);
	import bmst_pkg::*;
	`include "assert_macros.svh"

	logic [IDX_BITS-1:0] li;
	logic [POS_BITS-1:0] lp;
	logic signed [NEG_BITS-1:0] ln;
	assign {li, lp, ln} = in.data;

	cell_ctl_t       c  [LVLS+1];
	logic [LVLS-1:0] ix [LVLS+1];
	pair_t           pr [LVLS+1];

	logic busy_q, ovld_q;
	pair_t root_q;
	logic acc;
	logic done;
	cnt_t cp, cn;
	logic clr_q;
	logic [LVLS-1:0] clr_cnt_q;

	assign acc      = in.valid && in.ready;
	assign in.ready = !clr_q && !busy_q && !ovld_q;
	// clearing walks come out of the chain too; drop them
	assign done     = c[LVLS].go && !c[LVLS].clr;

	// clearing pass: one zero walk per leaf, one a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == '1)
				clr_q <= 1'b0;
		end
	end

	// clamp the leaf into the count range
	always_comb begin
		if (32'(lp) > 32'(CNT_MAX))
			cp = CNT_MAX;
		else
			cp = CB'(lp);
		if (ln > 0)
			cn = '0;
		else if (32'(signed'(ln)) < 32'(signed'(CNT_MIN)))
			cn = CNT_MIN;
		else
			cn = CB'(ln);
	end

	assign c[0]  = '{go: acc || clr_q, wr: clr_q || (32'(li) < 32'(LEAVES)), clr: clr_q};
	assign ix[0] = clr_q ? clr_cnt_q : LVLS'(li);
	assign pr[0] = clr_q ? '0 : '{pos: cp, neg: cn};

	for (genvar g = 0; g < LVLS; g++) begin : g_chain
		bmst_cell #(.LVL(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(c[g]), .idx_in(ix[g]), .pair_in(pr[g]),
			.ctl_out(c[g+1]), .idx_out(ix[g+1]), .pair_out(pr[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ovld_q <= 1'b0;
			root_q <= '0;
		end else begin
			if (acc)
				busy_q <= 1'b1;
			if (done) begin
				busy_q <= 1'b0;
				ovld_q <= 1'b1;
				if (c[LVLS].wr)
					root_q <= pr[LVLS];
			end else if (out.valid && out.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	logic [POS_BITS-1:0] rp;
	logic signed [NEG_BITS-1:0] rn;
	always_comb begin
		if (32'(signed'(root_q.pos)) > 32'sd32767)
			rp = 15'h7FFF;
		else if (root_q.pos < 0)
			rp = '0;
		else
			rp = POS_BITS'(root_q.pos);
		if (32'(signed'(root_q.neg)) < -32'sd32768)
			rn = 16'sh8000;
		else if (root_q.neg > 0)
			rn = '0;
		else
			rn = NEG_BITS'(root_q.neg);
	end
	assign out.valid = ovld_q;
	assign out.data  = {rp, rn};

	`ASSERT_IMPL(a_no_acc_busy, busy_q, !in.ready, "accept while busy")
	`ASSERT_NEXT(a_busy_after, acc, busy_q, "busy not raised")
	`ASSERT_IMPL(a_done_only_busy, done, busy_q && !ovld_q, "stray completion")
	`ASSERT_IMPL(a_root_surplus, 1'b1, root_q.pos >= 0 && root_q.neg <= 0, "root sign")
endmodule
